// ===== hw/rtl/wbi_pkg.sv =====
// ----------------------------------------------------------------------------
// Warped barycentric interpolator package
// Fixed-point types, warp coefficients and the shared arithmetic helpers.
// ----------------------------------------------------------------------------
package wbi_pkg;

  localparam int GRID_W       = 11;
  localparam int Q_W          = 32;
  localparam int PROD_W       = 2 * Q_W;
  localparam int FRAC_W       = 30;
  localparam int ROUND_W      = PROD_W - FRAC_W;
  localparam int SUM_W        = ROUND_W + 1;
  localparam int NUM_BITS     = FRAC_W + 1;
  localparam int DIV_BITS     = 4;
  localparam int DIV_STAGES   = (NUM_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int HORNER_STEPS = 5;

  typedef logic signed [Q_W-1:0]    q_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  qsum_t;
  typedef logic [GRID_W-1:0]        grid_t;

  typedef struct packed {
    logic                ovf;
    logic [GRID_W-1:0]   rem;
    logic [NUM_BITS-1:0] num;
    logic [NUM_BITS-1:0] quo;
  } div_t;

  localparam q_t Q_ONE = 32'sd1073741824;
  localparam q_t Q_MAX = 32'sd2147483647;
  localparam q_t Q_MIN = -32'sd2147483647 - 32'sd1;

  localparam q_t COEF5 = 32'sd57682055;
  localparam q_t COEF4 = -32'sd187331441;
  localparam q_t COEF3 = 32'sd314119949;
  localparam q_t COEF2 = -32'sd490003155;
  localparam q_t COEF1 = 32'sd1379274416;

  typedef q_t coef_arr_t [HORNER_STEPS];

  // The final Horner step only rounds the product, so it adds zero.
  localparam coef_arr_t HORNER_ADD = '{COEF4, COEF3, COEF2, COEF1, 32'sd0};

  localparam prod_t ROUND_HALF = prod_t'(1) <<< (FRAC_W - 1);

  function automatic q_t sat_q(input qsum_t v);
    q_t res;
    if (v[SUM_W-1] && !(&v[SUM_W-2:Q_W-1])) begin
      res = Q_MIN;
    end else if (!v[SUM_W-1] && (|v[SUM_W-2:Q_W-1])) begin
      res = Q_MAX;
    end else begin
      res = v[Q_W-1:0];
    end
    return res;
  endfunction

  function automatic q_t round_add(input prod_t prod, input q_t coef);
    prod_t rnd;
    qsum_t s;
    rnd = prod + ROUND_HALF;
    s   = qsum_t'($signed(rnd[PROD_W-1:FRAC_W])) + qsum_t'(coef);
    return sat_q(s);
  endfunction

  function automatic div_t div_init(input grid_t n, input grid_t d);
    div_t s;
    s.ovf = (n >> 1) >= d;
    s.rem = n >> 1;
    s.num = {n[0], (NUM_BITS-1)'(d >> 1)};
    s.quo = '0;
    return s;
  endfunction

  function automatic div_t div_step(input div_t s_in, input grid_t d, input int first_bit);
    div_t              s;
    logic [GRID_W:0]   r2;
    s = s_in;
    for (int b = 0; b < DIV_BITS; b++) begin
      if (first_bit + b < NUM_BITS) begin
        r2    = {s.rem, s.num[NUM_BITS-1]};
        s.num = s.num << 1;
        if (r2 >= {1'b0, d}) begin
          s.rem = GRID_W'(r2 - {1'b0, d});
          s.quo = {s.quo[NUM_BITS-2:0], 1'b1};
        end else begin
          s.rem = r2[GRID_W-1:0];
          s.quo = {s.quo[NUM_BITS-2:0], 1'b0};
        end
      end
    end
    return s;
  endfunction

endpackage

// ===== hw/rtl/warped_barycentric_interpolator.sv =====
// ----------------------------------------------------------------------------
// Warped barycentric interpolator
// Interpolates a point inside a subdivided triangle with warped weights.
// ----------------------------------------------------------------------------
// Each input item carries three corner points and a grid position; each item
// yields exactly one output item with the interpolated point, saturated Q16.16.
// The divisions register is written on the cfg channel, which is always ready.
// The user must write it only while no item is in flight; the block does not
// enforce this. Zero reads as one, values above MAX_DIVISIONS as MAX_DIVISIONS.
// The block is a 23-stage pipeline: an input stage and eight stages of
// restoring division (up to four quotient bits per stage), one weight
// stage, ten stages for the quintic warp (a multiply and a round/add stage
// per Horner step), then multiply, round and sum/saturate stages. One item
// is accepted every cycle unless the output is stalled and every stage is
// full. When the output is stalled, the stages ahead of the first empty
// stage keep moving, so empty slots are filled before in_tready drops.
// Synchronous reset clears every valid bit and sets divisions to one.
// ----------------------------------------------------------------------------
module warped_barycentric_interpolator
  import wbi_pkg::*;
#(
  parameter int COORD_WIDTH   = 32,
  parameter int MAX_DIVISIONS = 1024,
  localparam int IN_W  = ((9 * COORD_WIDTH + 2 * GRID_W + 7) / 8) * 8,
  localparam int OUT_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [GRID_W-1:0] cfg_data,
  input  logic             in_tvalid,
  output logic             in_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z,
  // third_x, third_y, third_z, grid_row, grid_col, zero fill
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // point_x, point_y, point_z, zero fill
  output logic [OUT_W-1:0] out_tdata
);

  localparam int CW      = COORD_WIDTH;
  localparam int ST_WGT  = DIV_STAGES + 1;
  localparam int ST_MUL  = ST_WGT + 2 * HORNER_STEPS + 1;
  localparam int ST_TERM = ST_MUL + 1;
  localparam int ST_OUT  = ST_TERM + 1;
  localparam int NST     = ST_OUT + 1;
  localparam int NTERM   = 9;
  localparam int A_W     = CW + 16;
  localparam int B_W     = CW + 17;
  localparam int TS_W    = CW + 18;
  localparam int T_W     = TS_W - 14;
  localparam int TOT_W   = T_W + 2;

  localparam logic signed [TS_W-1:0] TERM_HALF = TS_W'(1) <<< 13;

  logic [GRID_W-1:0] divisions_r, divisions_nxt;

  logic [NST-1:0] v_r, v_nxt, en;

  logic signed [CW-1:0] coord_r [0:ST_MUL-1][NTERM];
  div_t                 div_col_r [0:DIV_STAGES];
  div_t                 div_row_r [0:DIV_STAGES];
  q_t                   wgt_r [ST_WGT:ST_MUL-3][3];
  prod_t                prod_r [HORNER_STEPS][3];
  q_t                   p_r [HORNER_STEPS][3];
  logic signed [A_W-1:0] a_r [NTERM];
  logic signed [B_W-1:0] b_r [NTERM];
  logic signed [T_W-1:0] term_r [NTERM];
  logic signed [CW-1:0]  point_r [3];

  q_t                     w_col, w_row, w_first;
  qsum_t                  w_first_sum;
  logic signed [TS_W-1:0] term_sum [NTERM];
  logic signed [TOT_W-1:0] total [3];

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_comb begin
    divisions_nxt = divisions_r;
    if (cfg_valid) begin
      if (cfg_data == '0) begin
        divisions_nxt = GRID_W'(1);
      end else if (32'(cfg_data) > MAX_DIVISIONS) begin
        divisions_nxt = GRID_W'(MAX_DIVISIONS);
      end else begin
        divisions_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisions_r <= GRID_W'(1);
    end else begin
      divisions_r <= divisions_nxt;
    end
  end

  // A stage may load when it or any stage after it is empty, or the output
  // is being taken.
  always_comb begin
    for (int s = 0; s < NST; s++) begin
      en[s] = out_tready || !(&(v_r | NST'((1 << s) - 1)));
    end
    v_nxt = {v_r[NST-2:0], in_tvalid};
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < NST; s++) begin
        if (en[s]) begin
          v_r[s] <= v_nxt[s];
        end
      end
    end
  end

  // Input capture and coordinate delay line.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      div_col_r[0] <= div_init(in_tdata[9*CW+GRID_W +: GRID_W], divisions_r);
      div_row_r[0] <= div_init(in_tdata[9*CW +: GRID_W], divisions_r);
      for (int k = 0; k < NTERM; k++) begin
        coord_r[0][k] <= in_tdata[k*CW +: CW];
      end
    end
    for (int s = 1; s < ST_MUL; s++) begin
      if (en[s]) begin
        coord_r[s] <= coord_r[s-1];
      end
    end
  end

  // Flat weights by restoring division.
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en[k]) begin
        div_col_r[k] <= div_step(div_col_r[k-1], divisions_r, (k - 1) * DIV_BITS);
        div_row_r[k] <= div_step(div_row_r[k-1], divisions_r, (k - 1) * DIV_BITS);
      end
    end
  end

  always_comb begin
    w_col = div_col_r[DIV_STAGES].ovf ? Q_MAX : q_t'({1'b0, div_col_r[DIV_STAGES].quo});
    w_row = div_row_r[DIV_STAGES].ovf ? Q_MAX : q_t'({1'b0, div_row_r[DIV_STAGES].quo});
    w_first_sum = qsum_t'(Q_ONE) - qsum_t'(w_col) - qsum_t'(w_row);
    w_first = sat_q(w_first_sum);
  end

  always_ff @(posedge clk) begin
    if (en[ST_WGT]) begin
      wgt_r[ST_WGT][0] <= w_first;
      wgt_r[ST_WGT][1] <= w_col;
      wgt_r[ST_WGT][2] <= w_row;
    end
    for (int s = ST_WGT + 1; s <= ST_MUL - 3; s++) begin
      if (en[s]) begin
        wgt_r[s] <= wgt_r[s-1];
      end
    end
  end

  // Quintic warp in Horner form.
  for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_warp
    if (j == 0) begin : g_lead
      always_ff @(posedge clk) begin
        if (en[ST_WGT+1]) begin
          for (int i = 0; i < 3; i++) begin
            prod_r[0][i] <= prod_t'(COEF5) * prod_t'(wgt_r[ST_WGT][i]);
          end
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[ST_WGT+1+2*j]) begin
          for (int i = 0; i < 3; i++) begin
            prod_r[j][i] <= prod_t'(p_r[j-1][i]) * prod_t'(wgt_r[ST_WGT+2*j][i]);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[ST_WGT+2+2*j]) begin
        for (int i = 0; i < 3; i++) begin
          p_r[j][i] <= round_add(prod_r[j][i], HORNER_ADD[j]);
        end
      end
    end
  end

  // Corner scaling, split into high and low weight halves.
  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      for (int k = 0; k < NTERM; k++) begin
        a_r[k] <= A_W'(coord_r[ST_MUL-1][k])
                * A_W'($signed(p_r[HORNER_STEPS-1][k/3][Q_W-1:16]));
        b_r[k] <= B_W'(coord_r[ST_MUL-1][k])
                * B_W'($signed({1'b0, p_r[HORNER_STEPS-1][k/3][15:0]}));
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NTERM; k++) begin
      term_sum[k] = TS_W'(a_r[k]) + TERM_HALF + TS_W'($signed(b_r[k][B_W-1:16]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_TERM]) begin
      for (int k = 0; k < NTERM; k++) begin
        term_r[k] <= term_sum[k][TS_W-1:14];
      end
    end
  end

  // Per-axis sum and saturation to the coordinate range.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      total[a] = TOT_W'(term_r[a]) + TOT_W'(term_r[3+a]) + TOT_W'(term_r[6+a]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      for (int a = 0; a < 3; a++) begin
        if (total[a][TOT_W-1] && !(&total[a][TOT_W-2:CW-1])) begin
          point_r[a] <= {1'b1, {(CW-1){1'b0}}};
        end else if (!total[a][TOT_W-1] && (|total[a][TOT_W-2:CW-1])) begin
          point_r[a] <= {1'b0, {(CW-1){1'b1}}};
        end else begin
          point_r[a] <= total[a][CW-1:0];
        end
      end
    end
  end

  assign out_tdata = OUT_W'({point_r[2], point_r[1], point_r[0]});

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Warped barycentric interpolator testbench
// Streams corner triples and grid positions through the interpolator under
// several divisions settings and handshake pressure. A scoreboard computes
// each warped, saturated point and checks the output items in order.
// ----------------------------------------------------------------------------
module tb_top;
  import wbi_pkg::*;

  localparam int COORD_BITS   = 32;
  localparam int MAX_DIV      = 1024;
  localparam int IN_BITS      = ((9 * COORD_BITS + 2 * GRID_W + 7) / 8) * 8;
  localparam int OUT_BITS     = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int GRID_LSB     = 9 * COORD_BITS;
  localparam int PIPE_SLACK   = 30;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRESSURE_LEN = 300;

  typedef struct {
    q_t    corner[9];
    grid_t row;
    grid_t col;
  } point_req_t;

  typedef struct {
    q_t coord[3];
  } point_t;

  class point_scoreboard;
    grid_t  divisions;
    point_t expected_points[$];
    int     errors;

    function new();
      divisions = 1;
      errors    = 0;
    endfunction

    function void set_divisions(grid_t v);
      divisions = v;
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    function longint eff_divisions();
      if (divisions == 0) begin
        return 1;
      end
      if (divisions > MAX_DIV) begin
        return MAX_DIV;
      end
      return longint'(divisions);
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      if (v > hi) begin
        return hi;
      end
      if (v < lo) begin
        return lo;
      end
      return v;
    endfunction

    function longint sat_q30(longint v);
      return clamp(v, longint'(Q_MIN), longint'(Q_MAX));
    endfunction

    function longint round_q30(longint v);
      return (v + 64'sd536870912) >>> 30;
    endfunction

    function longint flat_weight(longint n, longint d);
      longint w;
      w = ((n <<< 30) + (d >>> 1)) / d;
      return (w > longint'(Q_MAX)) ? longint'(Q_MAX) : w;
    endfunction

    function longint warp_weight(longint w);
      longint p;
      p = longint'(COEF5);
      p = sat_q30(round_q30(p * w) + longint'(COEF4));
      p = sat_q30(round_q30(p * w) + longint'(COEF3));
      p = sat_q30(round_q30(p * w) + longint'(COEF2));
      p = sat_q30(round_q30(p * w) + longint'(COEF1));
      return sat_q30(round_q30(p * w));
    endfunction

    function point_t interpolate_point(point_req_t r);
      longint d;
      longint w[3];
      longint sum;
      point_t p;
      d    = eff_divisions();
      w[1] = flat_weight(longint'(r.col), d);
      w[2] = flat_weight(longint'(r.row), d);
      w[0] = sat_q30(64'sd1073741824 - w[1] - w[2]);
      for (int k = 0; k < 3; k++) begin
        w[k] = warp_weight(w[k]);
      end
      for (int a = 0; a < 3; a++) begin
        sum = 0;
        for (int k = 0; k < 3; k++) begin
          sum += round_q30(longint'(r.corner[3 * k + a]) * w[k]);
        end
        p.coord[a] = q_t'(clamp(sum, -64'sd2147483648, 64'sd2147483647));
      end
      return p;
    endfunction

    function void note_input(point_req_t r);
      expected_points.insert(expected_points.size(), interpolate_point(r));
    endfunction

    function void check_result(logic [OUT_BITS-1:0] data);
      point_t exp_pt;
      q_t     got;
      string  axis_names[3];
      axis_names = '{"x", "y", "z"};
      if (expected_points.size() == 0) begin
        $display("%0t: output item with no point expected, got %h", $time, data);
        errors++;
        return;
      end
      exp_pt = expected_points.pop_front();
      for (int a = 0; a < 3; a++) begin
        got = data[a * COORD_BITS +: COORD_BITS];
        if (got !== exp_pt.coord[a]) begin
          $display("%0t: point_%s expected %0d, got %0d", $time, axis_names[a],
                   exp_pt.coord[a], got);
          errors++;
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [GRID_W-1:0]   cfg_data;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_BITS-1:0]  in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_BITS-1:0] out_tdata;

  point_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int cycle_count;

  warped_barycentric_interpolator #(
    .COORD_WIDTH  (COORD_BITS),
    .MAX_DIVISIONS(MAX_DIV)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    point_req_t r;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else if (rst_n) begin
      if (in_tvalid && in_tready) begin
        for (int i = 0; i < 9; i++) begin
          r.corner[i] = in_tdata[i * COORD_BITS +: COORD_BITS];
        end
        r.row = in_tdata[GRID_LSB +: GRID_W];
        r.col = in_tdata[GRID_LSB + GRID_W +: GRID_W];
        sb.note_input(r);
      end
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata);
      end
    end
  end

  function automatic q_t random_coord();
    int sel;
    sel = $urandom_range(99);
    if (sel < 50) begin
      return q_t'($urandom());
    end else if (sel < 85) begin
      return q_t'(int'($urandom_range(4194304)) - 2097152);
    end
    case ($urandom_range(4))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return q_t'(0);
      3: return q_t'(65536);
      default: return q_t'(-65536);
    endcase
  endfunction

  // Corner pattern: all maximum, all minimum, alternating extremes, or random.
  function automatic point_req_t corners_for(int pattern);
    point_req_t r;
    for (int i = 0; i < 9; i++) begin
      case (pattern % 4)
        0: r.corner[i] = Q_MAX;
        1: r.corner[i] = Q_MIN;
        2: r.corner[i] = (i % 2 == 0) ? Q_MAX : Q_MIN;
        default: r.corner[i] = random_coord();
      endcase
    end
    r.row = '0;
    r.col = '0;
    return r;
  endfunction

  task automatic send_item(point_req_t r);
    int gap;
    logic [IN_BITS-1:0] bus;
    gap = 0;
    while (send_idle_pct > 0 && gap < 30 && $urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    bus = '0;
    for (int i = 0; i < 9; i++) begin
      bus[i * COORD_BITS +: COORD_BITS] = r.corner[i];
    end
    bus[GRID_LSB +: GRID_W]          = r.row;
    bus[GRID_LSB + GRID_W +: GRID_W] = r.col;
    @(negedge clk);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= bus;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_divisions(grid_t v);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_divisions(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Positions come in pairs of row and column.
  task automatic send_positions(int rc[$]);
    point_req_t r;
    for (int i = 0; i < rc.size() / 2; i++) begin
      r     = corners_for(i);
      r.row = grid_t'(rc[2 * i]);
      r.col = grid_t'(rc[2 * i + 1]);
      send_item(r);
    end
  endtask

  task automatic run_random(int count, int idle_pct, int stall_pct, grid_t div,
                            int hold);
    point_req_t r;
    int d;
    write_divisions(div);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (hold > 0) begin
      @(posedge clk);
      hold_cycles = hold;
    end
    d = int'(sb.eff_divisions());
    repeat (count) begin
      r = corners_for(3);
      if ($urandom_range(99) < 80) begin
        r.row = grid_t'($urandom_range(d));
        r.col = grid_t'($urandom_range(d - int'(r.row)));
      end else begin
        r.row = grid_t'($urandom());
        r.col = grid_t'($urandom());
      end
      send_item(r);
    end
  endtask

  initial begin
    sb             = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    cycle_count    = 0;
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset value of one division, then the extremes and out-of-range settings.
    send_positions({0, 0, 0, 1, 1, 0, 1, 1, 2047, 2047, 0, 0});
    write_divisions(grid_t'(1024));
    send_positions({0, 0, 1024, 0, 0, 1024, 512, 512, 1, 1, 341, 341,
                    1024, 1024, 2047, 0, 0, 2047, 1023, 1});
    write_divisions(grid_t'(0));
    send_positions({1, 0, 0, 1});
    write_divisions(grid_t'(2047));
    send_positions({1024, 0, 512, 1});

    run_random(160, 0, 0, grid_t'(3), 0);
    run_random(160, 62, 0, grid_t'(1024), 0);
    run_random(160, 0, 62, grid_t'(7), 0);
    run_random(160, 30, 30, grid_t'(1), 0);
    run_random(100, 0, 0, grid_t'(0), 0);
    run_random(100, 62, 0, grid_t'(2047), 0);
    run_random(160, 0, 62, grid_t'($urandom_range(1024, 2)), 0);
    run_random(150, 0, 0, grid_t'(64), PRESSURE_LEN);
    run_random(150, 30, 30, grid_t'(2), 0);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
